// ===== rtl/s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared types and constants for the seconds-to-calendar pipeline: calendar
// constants, reciprocal multipliers for the constant divisions, result types.
// ----------------------------------------------------------------------------
`default_nettype none

package s2c_pkg;

   // pipeline shape
   localparam int unsigned PIPE_DEPTH = 10;  // register stages, input to result
   localparam int unsigned TOD_DELAY  = 4;   // time-of-day alignment stages

   // field widths
   localparam int unsigned SECS_W   = 32;
   localparam int unsigned BIASED_W = 33;    // biased seconds, always positive
   localparam int unsigned DAYQ_W   = 17;    // biased day count
   localparam int unsigned REM_W    = 17;    // seconds within the day
   localparam int unsigned MDAY_W   = 20;    // March-based day count
   localparam int unsigned ERADAY_W = 18;    // day within the 400-year era
   localparam int unsigned ERAYR_W  = 9;     // year within the era
   localparam int unsigned YDAY_W   = 9;     // day within the March-based year

   // calendar constants
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned MINS_PER_HOUR = 60;
   localparam int unsigned DAYS_PER_WEEK = 7;
   localparam longint     SECS_PER_DAY  = 86400;
   localparam int unsigned DAY_LOW_BITS  = 7;     // 86400 = 675 << 7
   localparam int unsigned DAY_ODD       = 675;
   localparam longint     BIAS_DAYS     = 24856; // days added to make count positive
   localparam logic [BIASED_W-1:0] SEC_BIAS =
      BIASED_W'(BIAS_DAYS * SECS_PER_DAY - (64'sd1 <<< 31));
   localparam logic [MDAY_W-1:0] DAY_SHIFT = MDAY_W'(719468 - BIAS_DAYS);
   localparam logic [MDAY_W-1:0] WEEK_OFFSET = MDAY_W'(3);
   localparam longint     ERA_DAYS      = 146097;
   localparam logic [MDAY_W-1:0] ERA4_START = MDAY_W'(4 * ERA_DAYS);
   localparam logic [MDAY_W-1:0] ERA5_START = MDAY_W'(5 * ERA_DAYS);
   localparam logic [ERADAY_W-1:0] ERA_LAST_DAY = ERADAY_W'(ERA_DAYS - 1);
   localparam int unsigned YEAR_DAYS     = 365;
   localparam int unsigned MONTH_SPAN    = 153;   // days in five March-based months
   localparam int unsigned MONTHS_MAR_DEC = 10;
   localparam int unsigned MARCH_INDEX   = 2;
   localparam int unsigned MAR_TO_JAN    = 306;   // year day of January 1
   localparam int unsigned JAN_FEB_DAYS  = 59;
   localparam logic [9:0] ERA4_YEAR_ADJ = 10'(4 * 400 - 1900);
   localparam logic [9:0] ERA5_YEAR_ADJ = 10'(5 * 400 - 1900);

   // reciprocal multipliers: M = ceil(2^K / d), K = width(n) + width(d),
   // which makes floor(n * M / 2^K) exact over the whole operand range
   localparam int unsigned K_675   = 36;
   localparam logic [26:0] RECIP_675 =
      27'(((64'd1 << K_675) + 64'd674) / 64'd675);
   localparam int unsigned K_60S   = 23;
   localparam logic [17:0] RECIP_60S =
      18'(((64'd1 << K_60S) + 64'd59) / 64'd60);
   localparam int unsigned K_60M   = 17;
   localparam logic [11:0] RECIP_60M =
      12'(((64'd1 << K_60M) + 64'd59) / 64'd60);
   localparam int unsigned K_7     = 23;
   localparam logic [20:0] RECIP_7 =
      21'(((64'd1 << K_7) + 64'd6) / 64'd7);
   localparam int unsigned K_1460  = 29;
   localparam logic [18:0] RECIP_1460 =
      19'(((64'd1 << K_1460) + 64'd1459) / 64'd1460);
   localparam int unsigned K_36524 = 34;
   localparam logic [18:0] RECIP_36524 =
      19'(((64'd1 << K_36524) + 64'd36523) / 64'd36524);
   localparam int unsigned K_365   = 27;
   localparam logic [18:0] RECIP_365 =
      19'(((64'd1 << K_365) + 64'd364) / 64'd365);
   localparam int unsigned K_100   = 16;
   localparam logic [9:0] RECIP_100 =
      10'(((64'd1 << K_100) + 64'd99) / 64'd100);
   localparam int unsigned K_153   = 19;
   localparam logic [11:0] RECIP_153 =
      12'(((64'd1 << K_153) + 64'd152) / 64'd153);
   localparam int unsigned K_5     = 14;
   localparam logic [11:0] RECIP_5 =
      12'(((64'd1 << K_5) + 64'd4) / 64'd5);

   // result groups
   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
   } tod_type;

   typedef struct packed {
      logic [2:0] weekday;
      logic [4:0] day_of_month;
      logic [3:0] month_index;
      logic [7:0] years_since_1900;
      logic [8:0] day_of_year;
   } date_type;

endpackage

`default_nettype wire

// ===== rtl/s2c_day_split.sv =====
// ----------------------------------------------------------------------------
// s2c_day_split
// Three stages: splits signed epoch seconds into a March-based day count and
// the seconds within the day, flooring toward earlier days.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_day_split (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic signed [s2c_pkg::SECS_W-1:0] epoch_seconds,
   output logic [s2c_pkg::REM_W-1:0]              rem_ff,
   output logic [s2c_pkg::MDAY_W-1:0]             march_day_ff
);

   localparam int unsigned HI_W = s2c_pkg::BIASED_W - s2c_pkg::DAY_LOW_BITS;

   // stage 1: bias to a positive count, split off the factor 128
   logic [s2c_pkg::BIASED_W-1:0]     biased;
   logic [HI_W-1:0]                  high_ff;
   logic [s2c_pkg::DAY_LOW_BITS-1:0] low1_ff;

   assign biased = {1'b0, ~epoch_seconds[s2c_pkg::SECS_W-1],
                    epoch_seconds[s2c_pkg::SECS_W-2:0]} + s2c_pkg::SEC_BIAS;

   always_ff @(posedge clock) begin
      if (enable) begin
         high_ff <= biased[s2c_pkg::BIASED_W-1:s2c_pkg::DAY_LOW_BITS];
         low1_ff <= biased[s2c_pkg::DAY_LOW_BITS-1:0];
      end
   end

   // stage 2: divide by 675 through the reciprocal
   logic [HI_W+26:0]                 quot_prod;
   logic [s2c_pkg::DAYQ_W-1:0]       days_ff;
   logic [9:0]                       high_lo_ff;
   logic [s2c_pkg::DAY_LOW_BITS-1:0] low2_ff;

   assign quot_prod = (HI_W+27)'(high_ff) * (HI_W+27)'(s2c_pkg::RECIP_675);

   always_ff @(posedge clock) begin
      if (enable) begin
         days_ff    <= quot_prod[s2c_pkg::K_675+s2c_pkg::DAYQ_W-1:s2c_pkg::K_675];
         high_lo_ff <= high_ff[9:0];
         low2_ff    <= low1_ff;
      end
   end

   // stage 3: remainder (below 675, so ten bits are enough) and day shift
   logic [26:0] back_prod;
   logic [9:0]  rem_hi;

   assign back_prod = 27'(days_ff) * 27'(s2c_pkg::DAY_ODD);
   assign rem_hi    = high_lo_ff - back_prod[9:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff       <= {rem_hi, low2_ff};
         march_day_ff <= s2c_pkg::MDAY_W'(days_ff) + s2c_pkg::DAY_SHIFT;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/s2c_time_of_day.sv =====
// ----------------------------------------------------------------------------
// s2c_time_of_day
// Seven stages: hour, minute and second from the seconds within the day,
// delayed to line up with the date path.
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_time_of_day (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [s2c_pkg::REM_W-1:0]    rem,
   output s2c_pkg::tod_type                  tod
);

   // stage 4: whole minutes of the day
   logic [34:0] min_prod;
   logic [10:0] mins_ff;
   logic [5:0]  rem_lo_ff;

   assign min_prod = 35'(rem) * 35'(s2c_pkg::RECIP_60S);

   always_ff @(posedge clock) begin
      if (enable) begin
         mins_ff   <= min_prod[s2c_pkg::K_60S+10:s2c_pkg::K_60S];
         rem_lo_ff <= rem[5:0];
      end
   end

   // stage 5: second and hour
   logic [16:0] sec_back;
   logic [22:0] hour_prod;
   logic [5:0]  second_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  mins_lo_ff;

   assign sec_back  = 17'(mins_ff) * 17'(s2c_pkg::SECS_PER_MIN);
   assign hour_prod = 23'(mins_ff) * 23'(s2c_pkg::RECIP_60M);

   always_ff @(posedge clock) begin
      if (enable) begin
         second_ff  <= rem_lo_ff - sec_back[5:0];
         hour_ff    <= hour_prod[s2c_pkg::K_60M+4:s2c_pkg::K_60M];
         mins_lo_ff <= mins_ff[5:0];
      end
   end

   // stage 6: minute within the hour
   logic [10:0]      min_back;
   s2c_pkg::tod_type tod6_ff;

   assign min_back = 11'(hour_ff) * 11'(s2c_pkg::MINS_PER_HOUR);

   always_ff @(posedge clock) begin
      if (enable) begin
         tod6_ff.second <= second_ff;
         tod6_ff.minute <= mins_lo_ff - min_back[5:0];
         tod6_ff.hour   <= hour_ff;
      end
   end

   // stages 7 to 10: alignment with the date path
   s2c_pkg::tod_type dly_ff [s2c_pkg::TOD_DELAY];

   always_ff @(posedge clock) begin
      if (enable) begin
         dly_ff[0] <= tod6_ff;
         for (int i = 1; i < s2c_pkg::TOD_DELAY; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign tod = dly_ff[s2c_pkg::TOD_DELAY-1];

endmodule

`default_nettype wire

// ===== rtl/s2c_civil_date.sv =====
// ----------------------------------------------------------------------------
// s2c_civil_date
// Seven stages: weekday, year, month, day of month and day of year from the
// March-based day count (day 0 is 0000-03-01).
// ----------------------------------------------------------------------------
`default_nettype none

module s2c_civil_date (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [s2c_pkg::MDAY_W-1:0]    march_day,
   output s2c_pkg::date_type                  date_ff
);

   localparam int unsigned ED_W = s2c_pkg::ERADAY_W;
   localparam int unsigned EY_W = s2c_pkg::ERAYR_W;
   localparam int unsigned YD_W = s2c_pkg::YDAY_W;

   // stage 4: era (the input range spans eras 4 and 5), weekday quotient
   logic                 late_era;
   logic [19:0]          era_start;
   logic [19:0]          era_diff;
   logic [20:0]          week_num;
   logic [41:0]          week_prod;
   logic [ED_W-1:0]      eraday4_ff;
   logic                 late4_ff;
   logic [2:0]           wq4_ff;
   logic [2:0]           wn4_ff;

   assign late_era  = (march_day >= s2c_pkg::ERA5_START);
   assign era_start = late_era ? s2c_pkg::ERA5_START : s2c_pkg::ERA4_START;
   assign era_diff  = march_day - era_start;
   assign week_num  = 21'(march_day) + 21'(s2c_pkg::WEEK_OFFSET);
   assign week_prod = 42'(week_num) * 42'(s2c_pkg::RECIP_7);

   always_ff @(posedge clock) begin
      if (enable) begin
         eraday4_ff <= era_diff[ED_W-1:0];
         late4_ff   <= late_era;
         wq4_ff     <= week_prod[s2c_pkg::K_7+2:s2c_pkg::K_7];
         wn4_ff     <= week_num[2:0];
      end
   end

   // stage 5: weekday, four-year and century counts within the era
   logic [5:0]       week_back;
   logic [36:0]      quad_prod;
   logic [36:0]      cent_prod;
   logic [ED_W-1:0]  eraday5_ff;
   logic [6:0]       quads5_ff;
   logic [2:0]       cents5_ff;
   logic             last5_ff;
   logic             late5_ff;
   logic [2:0]       wk5_ff;

   assign week_back = 6'(wq4_ff) * 6'(s2c_pkg::DAYS_PER_WEEK);
   assign quad_prod = 37'(eraday4_ff) * 37'(s2c_pkg::RECIP_1460);
   assign cent_prod = 37'(eraday4_ff) * 37'(s2c_pkg::RECIP_36524);

   always_ff @(posedge clock) begin
      if (enable) begin
         eraday5_ff <= eraday4_ff;
         quads5_ff  <= quad_prod[s2c_pkg::K_1460+6:s2c_pkg::K_1460];
         cents5_ff  <= cent_prod[s2c_pkg::K_36524+2:s2c_pkg::K_36524];
         last5_ff   <= (eraday4_ff == s2c_pkg::ERA_LAST_DAY);
         late5_ff   <= late4_ff;
         wk5_ff     <= wn4_ff - week_back[2:0];
      end
   end

   // stage 6: day count with leap days folded out
   logic [ED_W-1:0]  folded6_ff;
   logic [ED_W-1:0]  eraday6_ff;
   logic             late6_ff;
   logic [2:0]       wk6_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         folded6_ff <= eraday5_ff + ED_W'(cents5_ff) - ED_W'(quads5_ff)
                       - ED_W'(last5_ff);
         eraday6_ff <= eraday5_ff;
         late6_ff   <= late5_ff;
         wk6_ff     <= wk5_ff;
      end
   end

   // stage 7: year within the era
   logic [36:0]      year_prod;
   logic [EY_W-1:0]  eyear7_ff;
   logic [ED_W-1:0]  eraday7_ff;
   logic             late7_ff;
   logic [2:0]       wk7_ff;

   assign year_prod = 37'(folded6_ff) * 37'(s2c_pkg::RECIP_365);

   always_ff @(posedge clock) begin
      if (enable) begin
         eyear7_ff  <= year_prod[s2c_pkg::K_365+EY_W-1:s2c_pkg::K_365];
         eraday7_ff <= eraday6_ff;
         late7_ff   <= late6_ff;
         wk7_ff     <= wk6_ff;
      end
   end

   // stage 8: day within the March-based year
   logic [ED_W-1:0]  year_start;
   logic [18:0]      c100_prod;
   logic [1:0]       c100;
   logic [ED_W-1:0]  yday_full;
   logic [YD_W-1:0]  yday8_ff;
   logic [EY_W-1:0]  eyear8_ff;
   logic [1:0]       c100_8_ff;
   logic             late8_ff;
   logic [2:0]       wk8_ff;

   assign c100_prod  = 19'(eyear7_ff) * 19'(s2c_pkg::RECIP_100);
   assign c100       = c100_prod[s2c_pkg::K_100+1:s2c_pkg::K_100];
   assign year_start = ED_W'(eyear7_ff) * ED_W'(s2c_pkg::YEAR_DAYS)
                       + ED_W'(eyear7_ff[EY_W-1:2]) - ED_W'(c100);
   assign yday_full  = eraday7_ff - year_start;

   always_ff @(posedge clock) begin
      if (enable) begin
         yday8_ff  <= yday_full[YD_W-1:0];
         eyear8_ff <= eyear7_ff;
         c100_8_ff <= c100;
         late8_ff  <= late7_ff;
         wk8_ff    <= wk7_ff;
      end
   end

   // stage 9: March-based month
   logic [10:0]      mon_num;
   logic [22:0]      mon_prod;
   logic [3:0]       mp9_ff;
   logic [YD_W-1:0]  yday9_ff;
   logic [EY_W-1:0]  eyear9_ff;
   logic [1:0]       c100_9_ff;
   logic             late9_ff;
   logic [2:0]       wk9_ff;

   assign mon_num  = 11'(yday8_ff) * 11'(5) + 11'(2);
   assign mon_prod = 23'(mon_num) * 23'(s2c_pkg::RECIP_153);

   always_ff @(posedge clock) begin
      if (enable) begin
         mp9_ff    <= mon_prod[s2c_pkg::K_153+3:s2c_pkg::K_153];
         yday9_ff  <= yday8_ff;
         eyear9_ff <= eyear8_ff;
         c100_9_ff <= c100_8_ff;
         late9_ff  <= late8_ff;
         wk9_ff    <= wk8_ff;
      end
   end

   // stage 10: day of month, month, year and day of year
   logic [10:0]      span_num;
   logic [22:0]      span_prod;
   logic [YD_W-1:0]  month_start;
   logic [YD_W-1:0]  mday_full;
   logic             jan_feb;
   logic [EY_W-1:0]  cent_year;
   logic             leap;
   logic [9:0]       year_full;

   assign span_num    = 11'(mp9_ff) * 11'(s2c_pkg::MONTH_SPAN) + 11'(2);
   assign span_prod   = 23'(span_num) * 23'(s2c_pkg::RECIP_5);
   assign month_start = span_prod[s2c_pkg::K_5+YD_W-1:s2c_pkg::K_5];
   assign mday_full   = yday9_ff - month_start + YD_W'(1);
   assign jan_feb     = (mp9_ff >= 4'(s2c_pkg::MONTHS_MAR_DEC));
   // Gregorian leap rule on the year within the era
   assign cent_year   = EY_W'(c100_9_ff) * EY_W'(100);
   assign leap        = ((eyear9_ff[1:0] == 2'b00) && (eyear9_ff != cent_year))
                        || (eyear9_ff == '0);
   assign year_full   = 10'(eyear9_ff)
                        + (late9_ff ? s2c_pkg::ERA5_YEAR_ADJ : s2c_pkg::ERA4_YEAR_ADJ)
                        + 10'(jan_feb);

   always_ff @(posedge clock) begin
      if (enable) begin
         date_ff.weekday          <= wk9_ff;
         date_ff.day_of_month     <= mday_full[4:0];
         date_ff.month_index      <= jan_feb ? mp9_ff - 4'(s2c_pkg::MONTHS_MAR_DEC)
                                             : mp9_ff + 4'(s2c_pkg::MARCH_INDEX);
         date_ff.years_since_1900 <= year_full[7:0];
         date_ff.day_of_year      <= (yday9_ff >= YD_W'(s2c_pkg::MAR_TO_JAN))
            ? yday9_ff - YD_W'(s2c_pkg::MAR_TO_JAN)
            : yday9_ff + YD_W'(s2c_pkg::JAN_FEB_DAYS) + YD_W'(leap);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/seconds_to_calendar.sv =====
// Throughput: one transaction per cycle; the ten-stage pipeline advances as a
// whole and holds while a finished response waits on rsp_ready.
// Reset (synchronous, active high) clears the stage valid bits only; the stage
// data registers are not reset and there is no clearing pass.
// ----------------------------------------------------------------------------
// seconds_to_calendar
// Pipelined conversion of signed epoch seconds to broken-down UTC calendar
// time: second, minute, hour, weekday, day of month, month, year, year day.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [s2c_pkg::SECS_W-1:0] req_epoch_seconds,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [5:0]                             rsp_second,
   output logic [5:0]                             rsp_minute,
   output logic [4:0]                             rsp_hour,
   output logic [2:0]                             rsp_weekday,
   output logic [4:0]                             rsp_day_of_month,
   output logic [3:0]                             rsp_month_index,
   output logic [7:0]                             rsp_years_since_1900,
   output logic [8:0]                             rsp_day_of_year
);

   // pipeline advances unless the last stage holds an untaken response
   logic                               enable;
   logic [s2c_pkg::PIPE_DEPTH-1:0]     vld_ff;
   logic [s2c_pkg::PIPE_DEPTH-1:0]     vld_in;
   logic [s2c_pkg::REM_W-1:0]          rem;
   logic [s2c_pkg::MDAY_W-1:0]         march_day;
   s2c_pkg::tod_type                   tod;
   s2c_pkg::date_type                  date;

   assign enable    = ~vld_ff[s2c_pkg::PIPE_DEPTH-1] | rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = vld_ff[s2c_pkg::PIPE_DEPTH-1];

   // valid bits travel with the stage data
   assign vld_in = {vld_ff[s2c_pkg::PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   // stages 1 to 3
   s2c_day_split u_day_split (
      .clock         (clock),
      .enable        (enable),
      .epoch_seconds (req_epoch_seconds),
      .rem_ff        (rem),
      .march_day_ff  (march_day)
   );

   // stages 4 to 10, time of day
   s2c_time_of_day u_time_of_day (
      .clock  (clock),
      .enable (enable),
      .rem    (rem),
      .tod    (tod)
   );

   // stages 4 to 10, date
   s2c_civil_date u_civil_date (
      .clock     (clock),
      .enable    (enable),
      .march_day (march_day),
      .date_ff   (date)
   );

   assign rsp_second           = tod.second;
   assign rsp_minute           = tod.minute;
   assign rsp_hour             = tod.hour;
   assign rsp_weekday          = date.weekday;
   assign rsp_day_of_month     = date.day_of_month;
   assign rsp_month_index      = date.month_index;
   assign rsp_years_since_1900 = date.years_since_1900;
   assign rsp_day_of_year      = date.day_of_year;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seconds-to-calendar pipeline. A table of
// directed timestamps is sent first: the epoch, the 32-bit limits, midnight
// edges, negative counts and leap days. Random timestamps follow under three
// idle patterns, with one long output hold-off. Every response is checked
// field by field against a behavioral calendar predictor or typed table values.
// ----------------------------------------------------------------------------

module testbench;

   // calendar arithmetic for the predictor
   localparam longint DAY_SECONDS      = 86400;
   localparam longint HOUR_SECONDS     = 3600;
   localparam longint MINUTE_SECONDS   = 60;
   localparam longint MARCH_ZERO_SHIFT = 719468;   // days from 0000-03-01 to epoch
   localparam longint ERA_LEN          = 146097;   // days in 400 years
   localparam longint CENTURY_LEN      = 36524;
   localparam longint QUAD_LEN         = 1461;
   localparam longint YEAR_LEN         = 365;
   localparam longint YEAR_ORIGIN      = 1900;
   localparam longint JAN_FIRST_YDAY   = 306;      // Jan 1 in a March-based year
   localparam longint JAN_FEB_LEN      = 59;

   // run shape
   localparam int RANDOM_ITEMS = 1450;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_LIMIT  = 20000;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [4:0] day_of_month;
      logic [3:0] month_index;
      logic [7:0] years_since_1900;
      logic [8:0] day_of_year;
   } calendar_type;

   typedef struct packed {
      logic [31:0]  epoch;
      calendar_type date;
   } conversion_type;

   typedef struct packed {
      logic [31:0]  epoch;
      logic         typed;
      calendar_type date;
   } table_row_type;

   localparam calendar_type DATE_NONE = '0;

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_index;
   logic [7:0]  rsp_years_since_1900;
   logic [8:0]  rsp_day_of_year;

   conversion_type pending_dates [$];
   table_row_type  directed_rows [$];
   int          mismatch_count = 0;
   int          send_gap_pct   = 0;
   int          recv_gap_pct   = 0;
   bit          hold_request   = 1'b0;
   bit          hold_taken     = 1'b0;
   int          hold_left      = 0;

   seconds_to_calendar uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second           (rsp_second),
      .rsp_minute           (rsp_minute),
      .rsp_hour             (rsp_hour),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_index      (rsp_month_index),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_day_of_year      (rsp_day_of_year)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

   // division rounding toward minus infinity, positive divisor
   function automatic longint floor_quot(input longint num, input longint den);
      if (num >= 0)
         return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // broken-down UTC date of a signed epoch second count
   function automatic calendar_type calendar_of(input logic [31:0] epoch);
      longint       secs;
      longint       days;
      longint       tod;
      longint       wday;
      longint       era;
      longint       era_day;
      longint       era_year;
      longint       mar_day;
      longint       mar_month;
      longint       month;
      longint       year;
      longint       leap;
      calendar_type date;
      secs = longint'($signed(epoch));
      days = floor_quot(secs, DAY_SECONDS);
      tod  = secs - days * DAY_SECONDS;
      date.hour   = 5'(tod / HOUR_SECONDS);
      date.minute = 6'((tod % HOUR_SECONDS) / MINUTE_SECONDS);
      date.second = 6'(tod % MINUTE_SECONDS);

      // move to the March-based count; 0000-03-01 was a Wednesday
      days = days + MARCH_ZERO_SHIFT;
      wday = (days + 3) % 7;
      if (wday < 0)
         wday = wday + 7;
      date.weekday = 3'(wday);

      era      = floor_quot(days, ERA_LEN);
      era_day  = days - era * ERA_LEN;
      era_year = (era_day - era_day / (QUAD_LEN - 1) + era_day / CENTURY_LEN
                  - era_day / (ERA_LEN - 1)) / YEAR_LEN;
      mar_day  = era_day - (YEAR_LEN * era_year + era_year / 4 - era_year / 100);
      mar_month = (5 * mar_day + 2) / 153;
      date.day_of_month = 5'(mar_day - (153 * mar_month + 2) / 5 + 1);
      month = (mar_month < 10) ? mar_month + 2 : mar_month - 10;
      date.month_index = 4'(month);
      year = era_year + era * 400 + ((month <= 1) ? 1 : 0);
      date.years_since_1900 = 8'(year - YEAR_ORIGIN);

      // Jan and Feb close the March-based year
      leap = ((era_year % 4 == 0 && era_year % 100 != 0) || era_year % 400 == 0) ? 1 : 0;
      if (mar_day >= JAN_FIRST_YDAY)
         date.day_of_year = 9'(mar_day - JAN_FIRST_YDAY);
      else
         date.day_of_year = 9'(mar_day + JAN_FEB_LEN + leap);
      return date;
   endfunction

   // random timestamp: mostly uniform, some midnight edges, values near zero and the limits
   function automatic logic [31:0] random_epoch();
      longint day;
      longint tod;
      unique case ($urandom_range(9))
         6, 7: begin
            day = longint'($urandom_range(49708)) - 24854;
            tod = $urandom_range(1) ? longint'($urandom_range(2))
                                    : DAY_SECONDS - 1 - longint'($urandom_range(2));
            return 32'(day * DAY_SECONDS + tod);
         end
         8: return 32'(longint'($urandom_range(200000)) - 100000);
         9: begin
            if ($urandom_range(1))
               return 32'h7FFF_FFFF - $urandom_range(99999);
            return 32'h8000_0000 + $urandom_range(99999);
         end
         default: return $urandom;
      endcase
   endfunction

   // offer one timestamp and hold it until the request is accepted
   task automatic offer(input logic [31:0] epoch, input calendar_type want);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= epoch;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back({epoch, want});
   endtask

   task automatic check_field(input string label, input logic [31:0] epoch,
                              input logic [8:0] got, input logic [8:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch for epoch %0d: expected %0d, got %0d",
                     $time, label, $signed(epoch), want, got);
      end
   endtask

   // output side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      conversion_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with no transaction outstanding", $time);
         end else begin
            head = pending_dates.pop_front();
            check_field("second", head.epoch, 9'(rsp_second), 9'(head.date.second));
            check_field("minute", head.epoch, 9'(rsp_minute), 9'(head.date.minute));
            check_field("hour", head.epoch, 9'(rsp_hour), 9'(head.date.hour));
            check_field("weekday", head.epoch, 9'(rsp_weekday), 9'(head.date.weekday));
            check_field("day_of_month", head.epoch, 9'(rsp_day_of_month),
                        9'(head.date.day_of_month));
            check_field("month_index", head.epoch, 9'(rsp_month_index),
                        9'(head.date.month_index));
            check_field("years_since_1900", head.epoch, 9'(rsp_years_since_1900),
                        9'(head.date.years_since_1900));
            check_field("day_of_year", head.epoch, rsp_day_of_year,
                        head.date.day_of_year);
         end
      end
   end

   // stimulus
   initial begin
      int           wait_cycles;
      logic [31:0]  epoch;
      calendar_type want;

      // typed rows: epoch, -1, both 32-bit limits
      directed_rows.push_back({32'd0, 1'b1,
         calendar_type'{6'd0, 6'd0, 5'd0, 3'd4, 5'd1, 4'd0, 8'd70, 9'd0}});
      directed_rows.push_back({32'hFFFF_FFFF, 1'b1,
         calendar_type'{6'd59, 6'd59, 5'd23, 3'd3, 5'd31, 4'd11, 8'd69, 9'd364}});
      directed_rows.push_back({32'h7FFF_FFFF, 1'b1,
         calendar_type'{6'd7, 6'd14, 5'd3, 3'd2, 5'd19, 4'd0, 8'd138, 9'd18}});
      directed_rows.push_back({32'h8000_0000, 1'b1,
         calendar_type'{6'd52, 6'd45, 5'd20, 3'd5, 5'd13, 4'd11, 8'd1, 9'd346}});
      // minute and hour edges, and midnight edges on both sides of zero
      directed_rows.push_back({32'd59, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd60, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd3599, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd3600, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd86399, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd86400, 1'b0, DATE_NONE});
      directed_rows.push_back({-32'sd86400, 1'b0, DATE_NONE});
      directed_rows.push_back({-32'sd86401, 1'b0, DATE_NONE});
      // leap days and year ends
      directed_rows.push_back({32'd68169600, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd951782400, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd951868799, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd951868800, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd978220799, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd1078012800, 1'b0, DATE_NONE});
      directed_rows.push_back({-32'sd631152000, 1'b0, DATE_NONE});
      directed_rows.push_back({32'd1700000000, 1'b0, DATE_NONE});
      // alternating bit patterns
      directed_rows.push_back({32'h5555_5555, 1'b0, DATE_NONE});
      directed_rows.push_back({32'hAAAA_AAAA, 1'b0, DATE_NONE});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 7;
      recv_gap_pct = 61;
      foreach (directed_rows[i])
         offer(directed_rows[i].epoch,
               directed_rows[i].typed ? directed_rows[i].date
                                      : calendar_of(directed_rows[i].epoch));

      // random traffic in three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               send_gap_pct = 7;
               recv_gap_pct = 61;
            end
            1: begin
               send_gap_pct = 61;
               recv_gap_pct = 7;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
               hold_request = 1'b1;   // fill the pipe against a stalled output
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            epoch = random_epoch();
            want  = calendar_of(epoch);
            offer(epoch, want);
         end
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline run out
      wait_cycles = 0;
      while (pending_dates.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (s2c_pkg::PIPE_DEPTH + 5) @(posedge clock);

      if (mismatch_count == 0 && pending_dates.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/s2c_pkg.sv
rtl/s2c_day_split.sv
rtl/s2c_time_of_day.sv
rtl/s2c_civil_date.sv
rtl/seconds_to_calendar.sv
test/testbench.sv
